// File: rtl/patm_pkg.sv
package patm_pkg;

   localparam int GAP_W           = 48;
   localparam int TIME_W          = 64;
   localparam int MEAN_FRAC_BITS  = 16;
   localparam int MEAN_W          = GAP_W + MEAN_FRAC_BITS;
   localparam int WINDOW_SHIFT    = 3;
   localparam int CERT_W          = 17;
   localparam int CSR_IDX_W       = 2;
   localparam int REQ_DATA_W      = 2 * TIME_W;
   localparam int RSP_DATA_W      = 24;

   localparam logic [CERT_W-1:0] CERT_ONE = CERT_W'(1) << (CERT_W - 1);
   localparam logic [GAP_W-1:0]  GAP_MAX  = '1;

   localparam logic [GAP_W-1:0] MIN_GAP_RST   = GAP_W'(1000);
   localparam logic [GAP_W-1:0] LATE_ALW_RST  = GAP_W'(1000000);
   localparam logic [GAP_W-1:0] BAL_BAND_RST  = GAP_W'(1000000);

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LATE_ALW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAL_BAND = 2'd2;

   typedef struct packed {
      logic [GAP_W-1:0] minimum_gap;
      logic [GAP_W-1:0] lateness_allowance;
      logic [GAP_W-1:0] balance_band;
   } cfg_type;

   typedef struct packed {
      logic              short_gap;
      logic              late;
      logic              unbalanced;
      logic [CERT_W-1:0] certainty_level;
   } result_type;

endpackage

// File: rtl/patm_csr.sv
module patm_csr
   import patm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAP_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      // a zero write leaves the register unchanged
      if (csr_we && (csr_wdata != '0)) begin
         unique case (csr_index)
            CSR_MIN_GAP:  cfg_in.minimum_gap        = csr_wdata;
            CSR_LATE_ALW: cfg_in.lateness_allowance = csr_wdata;
            CSR_BAL_BAND: cfg_in.balance_band       = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.minimum_gap        <= MIN_GAP_RST;
         cfg_ff.lateness_allowance <= LATE_ALW_RST;
         cfg_ff.balance_band       <= BAL_BAND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/patm_core.sv
module patm_core
   import patm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [TIME_W-1:0] arrival_time,
   input  logic [TIME_W-1:0] deadline_time,
   input  cfg_type           cfg,
   output result_type        result
);

   logic               seen_any_ff, seen_any_in;
   logic [TIME_W-1:0]  prev_arrival_ff, prev_arrival_in;
   logic [MEAN_W-1:0]  mean_gap_ff, mean_gap_in;
   logic [1:0]         arrivals_ff, arrivals_in;
   logic [CERT_W-1:0]  cert_ff, cert_in;

   logic [TIME_W-1:0]  late_diff;
   logic [TIME_W-1:0]  gap_raw;
   logic [GAP_W-1:0]   gap;
   logic [MEAN_W-1:0]  gap_fx;
   logic [MEAN_W-1:0]  band_fx;
   logic [MEAN_W-1:0]  dev;
   logic [MEAN_W-1:0]  dev_step;
   logic               gap_ge_mean;
   logic               short_gap;
   logic               late;
   logic               unbalanced;
   logic [CERT_W-1:0]  cert_next;

   always_comb begin
      late_diff = arrival_time - deadline_time;
      late = (deadline_time != '0) && (arrival_time > deadline_time) &&
             (late_diff > TIME_W'(cfg.lateness_allowance));

      gap_raw = (arrival_time >= prev_arrival_ff) ? (arrival_time - prev_arrival_ff) : '0;
      gap     = (gap_raw > TIME_W'(GAP_MAX)) ? GAP_MAX : gap_raw[GAP_W-1:0];
      gap_fx  = MEAN_W'(gap) << MEAN_FRAC_BITS;
      band_fx = MEAN_W'(cfg.balance_band) << MEAN_FRAC_BITS;

      gap_ge_mean = (gap_fx >= mean_gap_ff);
      dev         = gap_ge_mean ? (gap_fx - mean_gap_ff) : (mean_gap_ff - gap_fx);
      dev_step    = dev >> WINDOW_SHIFT;

      short_gap  = seen_any_ff && (gap < cfg.minimum_gap);
      unbalanced = seen_any_ff && (arrivals_ff == 2'd2) && (dev > band_fx);

      mean_gap_in = mean_gap_ff;
      if (seen_any_ff) begin
         if (arrivals_ff == 2'd1) begin
            mean_gap_in = gap_fx;
         end else if (gap_ge_mean) begin
            mean_gap_in = mean_gap_ff + dev_step;
         end else begin
            mean_gap_in = mean_gap_ff - dev_step;
         end
      end

      if (!(short_gap || late || unbalanced)) begin
         cert_next = cert_ff + ((CERT_ONE - cert_ff) >> WINDOW_SHIFT);
      end else begin
         cert_next = cert_ff - (cert_ff >> WINDOW_SHIFT);
      end
      cert_in = (cert_next > CERT_ONE) ? CERT_ONE : cert_next;

      seen_any_in     = 1'b1;
      prev_arrival_in = arrival_time;
      arrivals_in     = (arrivals_ff == 2'd2) ? arrivals_ff : arrivals_ff + 2'd1;

      result.short_gap       = short_gap;
      result.late            = late;
      result.unbalanced      = unbalanced;
      result.certainty_level = cert_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_any_ff     <= 1'b0;
         prev_arrival_ff <= '0;
         mean_gap_ff     <= '0;
         arrivals_ff     <= 2'd0;
         cert_ff         <= CERT_ONE;
      end else if (advance) begin
         seen_any_ff     <= seen_any_in;
         prev_arrival_ff <= prev_arrival_in;
         mean_gap_ff     <= mean_gap_in;
         arrivals_ff     <= arrivals_in;
         cert_ff         <= cert_in;
      end
   end

endmodule

// File: rtl/packet_arrival_timing_monitor.sv
// Packet arrival timing monitor.
// req_ channel: one beat per packet, carrying its arrival time and an optional
// deadline (zero means no deadline). rsp_ channel: one beat per packet with
// the short-gap, late and unbalanced flags and the certainty level (Q1.16).
// csr_ port: write-only; minimum gap, lateness allowance and balance band.
// A zero write or an unknown index leaves the registers as they are.
// A beat accepted on req_ passes through the input register, then the result
// register, before it shows on rsp_. Throughput: one beat per cycle while
// rsp_tready stays high; the whole update (64-bit subtracts, compares, mean
// and certainty step) sits between the input register and the result register.
// Reset clears the history (no previous arrival, mean zero, certainty 1.0)
// and restores the register defaults.
// When rsp_tready is low the result register holds, the input register
// still fills, and req_tready drops only once both are occupied.
module packet_arrival_timing_monitor
   import patm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // arrival_time, deadline_time
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // short_gap, late, unbalanced,
                                              // certainty_level, zero pad
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [GAP_W-1:0]      csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   patm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   patm_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .arrival_time  (in_data_ff[TIME_W-1:0]),
      .deadline_time (in_data_ff[REQ_DATA_W-1:TIME_W]),
      .cfg           (cfg),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= RSP_DATA_W'({result.certainty_level, result.unbalanced,
                                     result.late, result.short_gap});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: tb/sv/packet_arrival_timing_monitor_test.sv
`timescale 1ns / 1ps

module packet_arrival_timing_monitor_test;
   import patm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASES        = 8;
   localparam int BEATS_PER_PHASE = 150;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT    = 2000;

   // Expected-result tracker: mirrors the monitor's history and registers.
   class arrival_scoreboard;
      cfg_type           regs;
      logic              have_prev;
      logic [TIME_W-1:0] prev_arrival;
      logic [MEAN_W-1:0] mean_fx;
      logic [1:0]        seen_count;
      logic [CERT_W-1:0] cert;
      result_type        expected_q[$];
      int                mismatches;

      function new();
         regs.minimum_gap        = MIN_GAP_RST;
         regs.lateness_allowance = LATE_ALW_RST;
         regs.balance_band       = BAL_BAND_RST;
         have_prev    = 1'b0;
         prev_arrival = '0;
         mean_fx      = '0;
         seen_count   = '0;
         cert         = CERT_ONE;
         mismatches   = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [GAP_W-1:0] value);
         if (value == '0) return;
         case (idx)
            CSR_MIN_GAP:  regs.minimum_gap = value;
            CSR_LATE_ALW: regs.lateness_allowance = value;
            CSR_BAL_BAND: regs.balance_band = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic [TIME_W-1:0] arrival, logic [TIME_W-1:0] deadline);
         result_type        r;
         logic [TIME_W-1:0] gap;
         logic [MEAN_W-1:0] gap_fx, band_fx, dev;
         r = '0;
         r.late = (deadline != '0) && (arrival > deadline) &&
                  ((arrival - deadline) > {16'b0, regs.lateness_allowance});
         if (have_prev) begin
            gap = (arrival >= prev_arrival) ? arrival - prev_arrival : '0;
            if (gap > {16'b0, GAP_MAX}) gap = {16'b0, GAP_MAX};
            r.short_gap = gap < {16'b0, regs.minimum_gap};
            gap_fx  = gap << MEAN_FRAC_BITS;
            band_fx = {16'b0, regs.balance_band} << MEAN_FRAC_BITS;
            dev = (gap_fx >= mean_fx) ? gap_fx - mean_fx : mean_fx - gap_fx;
            r.unbalanced = (seen_count >= 2) && (dev > band_fx);
            if (seen_count == 1) mean_fx = gap_fx;
            else if (gap_fx >= mean_fx) mean_fx = mean_fx + (dev >> WINDOW_SHIFT);
            else mean_fx = mean_fx - (dev >> WINDOW_SHIFT);
         end
         if (!(r.short_gap || r.late || r.unbalanced)) begin
            cert = cert + ((CERT_ONE - cert) >> WINDOW_SHIFT);
         end else begin
            cert = cert - (cert >> WINDOW_SHIFT);
         end
         prev_arrival = arrival;
         have_prev = 1'b1;
         if (seen_count < 2) seen_count = seen_count + 2'd1;
         r.certainty_level = cert;
         expected_q.push_back(r);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // rsp_tdata, low bit up: short_gap, late, unbalanced, certainty_level
      function void check_response(logic [RSP_DATA_W-1:0] data);
         result_type got, want;
         got.short_gap       = data[0];
         got.late            = data[1];
         got.unbalanced      = data[2];
         got.certainty_level = data[3 +: CERT_W];
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing pending: %h", data));
            return;
         end
         want = expected_q.pop_front();
         if (got.short_gap !== want.short_gap || got.late !== want.late ||
             got.unbalanced !== want.unbalanced ||
             got.certainty_level !== want.certainty_level) begin
            report($sformatf({"mismatch: short_gap %b/%b late %b/%b unbalanced %b/%b ",
                              "certainty %0d/%0d (expected/actual)"},
                             want.short_gap, got.short_gap, want.late, got.late,
                             want.unbalanced, got.unbalanced,
                             want.certainty_level, got.certainty_level));
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // arrival_time, deadline_time
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // short_gap, late, unbalanced,
                                        // certainty_level, zero pad
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [GAP_W-1:0]      csr_wdata;

   arrival_scoreboard sb = new();

   logic [TIME_W-1:0] nominal_gap;
   logic [TIME_W-1:0] last_arrival;
   int unsigned       burst_left;
   logic [15:0]       stall_pattern = '1;
   logic [3:0]        stall_pos = '0;
   int unsigned       idle_cycles;

   packet_arrival_timing_monitor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver stalls: a 16-bit ready pattern, redrawn each time it wraps.
   always @(negedge clock) begin
      rsp_tready <= stall_pattern[stall_pos];
      stall_pos <= stall_pos + 4'd1;
      if (stall_pos == 4'hF) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= '1;
            1: stall_pattern <= 16'($urandom);
            2: stall_pattern <= 16'($urandom) | 16'($urandom);
            default: stall_pattern <= 16'($urandom) & 16'($urandom);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata[TIME_W-1:0], req_tdata[REQ_DATA_W-1:TIME_W]);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_we) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("packet_arrival_timing_monitor verification failed");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_upto(logic [63:0] limit);
      return rand64() % (limit + 1);
   endfunction

   function automatic logic [GAP_W-1:0] random_reg();
      return GAP_W'(rand64() >> $urandom_range(16, 62));
   endfunction

   // Gap around the phase's nominal value, jitter on the order of the band.
   function automatic logic [TIME_W-1:0] jittered_gap();
      logic [TIME_W-1:0] span, offset;
      span = {16'b0, sb.regs.balance_band} << $urandom_range(0, 1);
      offset = rand_upto(2 * span);
      if (offset >= span) return nominal_gap + (offset - span);
      return (nominal_gap > span - offset) ? nominal_gap - (span - offset) : '0;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_packet(input logic [TIME_W-1:0] arrival, deadline);
      req_tvalid <= 1'b1;
      req_tdata  <= {deadline, arrival};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      last_arrival = arrival;
   endtask

   task automatic send_paced(input logic [TIME_W-1:0] arrival, deadline);
      int unsigned pause;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (pause != 0) begin
            req_tvalid <= 1'b0;
            repeat (pause) @(negedge clock);
         end
      end
      burst_left--;
      send_packet(arrival, deadline);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [GAP_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic configure(input logic [GAP_W-1:0] min_gap, allowance, band);
      write_csr(CSR_MIN_GAP, min_gap);
      write_csr(CSR_LATE_ALW, allowance);
      write_csr(CSR_BAL_BAND, band);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_packet();
      logic [TIME_W-1:0] arrival, deadline, allowance;
      int unsigned       pick;
      allowance = {16'b0, sb.regs.lateness_allowance};
      pick = $urandom_range(0, 99);
      if (pick < 75) arrival = last_arrival + jittered_gap();
      else if (pick < 85) arrival = rand64();
      else if (pick < 92) arrival = last_arrival - rand_upto(64'd2000);
      else arrival = last_arrival + (rand64() >> $urandom_range(0, 15));
      case ($urandom_range(0, 9))
         0, 1, 2: deadline = '0;
         3: deadline = arrival - allowance;
         4: deadline = arrival - allowance - 1;
         5: deadline = arrival - allowance + 1;
         6: deadline = arrival + rand_upto(64'd1000);
         7: deadline = rand64();
         default: deadline = arrival - rand_upto(2 * allowance);
      endcase
      send_paced(arrival, deadline);
   endtask

   // First arrival, seeding, short-gap boundary, late boundary, backwards
   // time, saturated gap, full-scale timestamps.
   logic [TIME_W-1:0] directed_arrival [14] = '{
      64'd0, 64'd5000, 64'd10000, 64'd10999, 64'd11999, 64'd2000000,
      64'd2000001, 64'd1999000, '1, '1, 64'd0, 64'h8000_0000_0000_0000,
      64'h8000_0000_0000_1388, 64'h8000_0000_0000_2710};
   logic [TIME_W-1:0] directed_deadline [14] = '{
      64'd0, 64'd0, 64'd0, 64'd1, 64'd0, 64'd1000000,
      64'd1000000, 64'd1999005, 64'd1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF,
      64'd0, 64'h8000_0000_0000_2710};

   initial begin
      int phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      burst_left = 0;
      last_arrival = '0;
      nominal_gap  = 64'd5000;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_arrival[k]) send_packet(directed_arrival[k], directed_deadline[k]);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: ;
            1: configure(GAP_W'(1), GAP_W'(1), GAP_W'(1));
            2: configure(GAP_MAX, GAP_MAX, GAP_MAX);
            3: begin
               // unknown index and zero writes must leave the registers alone
               write_csr(CSR_UNUSED, random_reg() | GAP_W'(1));
               configure('0, '0, '0);
            end
            default: configure(random_reg(), random_reg(), random_reg());
         endcase
         case ($urandom_range(0, 2))
            0: nominal_gap = {16'b0, sb.regs.minimum_gap} +
                             rand_upto({16'b0, sb.regs.minimum_gap});
            1: nominal_gap = {16'b0, sb.regs.balance_band} << 2;
            default: nominal_gap = rand64() >> $urandom_range(24, 44);
         endcase
         repeat (BEATS_PER_PHASE) begin
            if ($urandom_range(0, 199) == 0) wait_drained();
            send_random_packet();
         end
      end

      wait_drained();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("packet_arrival_timing_monitor verification clean");
      end else begin
         $display("packet_arrival_timing_monitor verification failed");
      end
      $finish;
   end

endmodule
